### rtl/core/hbct_pkg.sv
// shared types and constants of the hashed block cache tag table
package hbct_pkg;

  // default sizing
  localparam int SLOTS_DEF       = 1024;
  localparam int BLOCK_BITS_DEF  = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fixed field widths
  localparam int ACT_W      = 3;
  localparam int DISK_ID_W  = 16;
  localparam int SECTOR_W   = 32;
  localparam int OUT_SLOT_W = 10;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // hash multiplier
  localparam logic [21:0] HASH_MUL = 22'd2606459;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_FETCH   = 3'd0,
    ACT_UNLOCK  = 3'd1,
    ACT_STORE   = 3'd2,
    ACT_INVAL   = 3'd3,
    ACT_INV_ALL = 3'd4
  } action_e;

  // request as it travels from front to back, slot index carried beside it
  typedef struct packed {
    logic [ACT_W-1:0]     act;
    logic [DISK_ID_W-1:0] disk_id;
    logic [SECTOR_W-1:0]  sector;
  } cmd_t;

endpackage

### rtl/core/hbct_front.sv
// front end: accepts request beats, aligns the sector and computes the slot index
module hbct_front #(
  parameter int SLOTS      = hbct_pkg::SLOTS_DEF,
  parameter int BLOCK_BITS = hbct_pkg::BLOCK_BITS_DEF,
  parameter int SW         = $clog2(SLOTS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: action[2:0], disk_id[18:3], sector[50:19], zero pad
  input  logic [hbct_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           clear_busy,
  input  logic                           q_full,
  output logic                           push,
  output hbct_pkg::cmd_t                 push_cmd,
  output logic [SW-1:0]                  push_slot
);

  localparam logic [31:0] ALIGN_MASK = ~((32'd1 << BLOCK_BITS) - 32'd1);
  localparam logic [63:0] RECIP64    = 64'h1_0000_0000 / 64'(SLOTS);
  localparam logic [31:0] RECIP      = RECIP64[31:0];
  localparam logic [31:0] SLOTS32    = 32'(SLOTS);

  logic           v0_r, v1_r, v2_r, v3_r, v4_r;
  hbct_pkg::cmd_t c0_r, c1_r, c2_r, c3_r, c4_r;
  logic [31:0]    h1_r, h2_r, h3_r;
  logic [31:0]    q2_r, m3_r;
  logic [SW-1:0]  slot4_r;
  logic           adv;
  logic [37:0]    prod1;
  logic [63:0]    prod2, prod3;
  logic [31:0]    rem, rem_c;

  // whole pipeline moves together when the last stage can drain
  assign adv       = !v4_r || !q_full;
  assign in_tready = adv && !clear_busy;
  assign push      = v4_r && !q_full;
  assign push_cmd  = c4_r;
  assign push_slot = slot4_r;

  // hash, reciprocal quotient estimate, product back and remainder
  assign prod1 = {16'b0, c0_r.disk_id} * {16'b0, hbct_pkg::HASH_MUL};
  assign prod2 = {32'b0, h1_r} * {32'b0, RECIP};
  assign prod3 = {32'b0, q2_r} * {32'b0, SLOTS32};
  assign rem   = h3_r - m3_r;
  assign rem_c = (rem >= SLOTS32) ? (rem - SLOTS32) : rem;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid && in_tready;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r.act     <= in_tdata[2:0];
      c0_r.disk_id <= in_tdata[18:3];
      c0_r.sector  <= in_tdata[50:19] & ALIGN_MASK;
      c1_r    <= c0_r;
      h1_r    <= prod1[31:0] + (c0_r.sector >> BLOCK_BITS);
      c2_r    <= c1_r;
      h2_r    <= h1_r;
      q2_r    <= prod2[63:32];
      c3_r    <= c2_r;
      h3_r    <= h2_r;
      m3_r    <= prod3[31:0];
      c4_r    <= c3_r;
      slot4_r <= rem_c[SW-1:0];
    end
  end

endmodule

### rtl/core/hbct_queue.sv
// short request queue between front and back
module hbct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hbct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = entry_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

endmodule

### rtl/core/hbct_back.sv
// back end: tag memory, read-modify-write of one slot, invalidate-all sweep, result register
module hbct_back #(
  parameter int SLOTS = hbct_pkg::SLOTS_DEF,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  hbct_pkg::cmd_t                  q_cmd,
  input  logic [SW-1:0]                   q_slot,
  output logic                            pop,
  output logic                            clear_busy,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fields from bit 0: hit[0], slot[10:1], zero pad
  output logic [hbct_pkg::OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_SWEND = 5'b10000
  } back_state_t;

  typedef struct packed {
    logic        lock;
    logic        valid;
    logic [31:0] sector;
    logic [15:0] disk_id;
  } slot_word_t;

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  slot_word_t     mem [SLOTS];
  slot_word_t     rd_data_r;
  slot_word_t     wr_data, upd;
  logic           rd_en, wr_en;
  logic [SW-1:0]  rd_addr, wr_addr;

  back_state_t    state_r, state_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]  wb_addr_r, wb_addr_nxt;
  logic           wb_v_r, wb_v_nxt;
  hbct_pkg::cmd_t cur_r;
  logic [SW-1:0]  cur_slot_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_hit_r, res_hit;
  logic [SW-1:0]  out_slot_r, res_slot;
  logic           res_load;
  logic           out_free;
  logic           match;
  logic [SW+9:0]  slot_ext;

  assign out_free   = !out_valid_r || out_tready;
  assign clear_busy = (state_r == ST_CLEAR);
  assign out_tvalid = out_valid_r;
  assign slot_ext   = {10'b0, out_slot_r};
  assign out_tdata  = {5'b0, slot_ext[9:0], out_hit_r};

  assign match = rd_data_r.valid && (rd_data_r.disk_id == cur_r.disk_id)
                 && (rd_data_r.sector == cur_r.sector);

  // updated word for a single-slot action
  always_comb begin
    upd = rd_data_r;
    case (cur_r.act)
      hbct_pkg::ACT_FETCH: begin
        if (match) upd.lock = 1'b1;
      end
      hbct_pkg::ACT_UNLOCK: begin
        if (match) upd.lock = 1'b0;
      end
      hbct_pkg::ACT_STORE: begin
        if (match) upd.lock = 1'b0;
        upd.valid   = 1'b1;
        upd.sector  = cur_r.sector;
        upd.disk_id = cur_r.disk_id;
      end
      hbct_pkg::ACT_INVAL: begin
        if (match) begin
          upd.lock  = 1'b0;
          upd.valid = 1'b0;
        end
      end
      default: begin
        upd = rd_data_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wb_addr_nxt = wb_addr_r;
    wb_v_nxt    = wb_v_r;
    pop         = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = q_slot;
    wr_en       = 1'b0;
    wr_addr     = cur_slot_r;
    wr_data     = upd;
    res_load    = 1'b0;
    res_hit     = 1'b0;
    res_slot    = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = cnt_r;
        wr_data       = '0;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          if (q_cmd.act == hbct_pkg::ACT_INV_ALL) begin
            cnt_nxt   = '0;
            wb_v_nxt  = 1'b0;
            state_nxt = ST_SWEEP;
          end else if (q_cmd.act inside {hbct_pkg::ACT_FETCH, hbct_pkg::ACT_UNLOCK,
                                         hbct_pkg::ACT_STORE, hbct_pkg::ACT_INVAL}) begin
            rd_en     = 1'b1;
            state_nxt = ST_EXEC;
          end else begin
            // unknown action: answer at once, no table change
            res_load = 1'b1;
          end
        end
      end
      ST_EXEC: begin
        wr_en     = 1'b1;
        res_load  = 1'b1;
        res_hit   = match && (cur_r.act inside {hbct_pkg::ACT_FETCH,
                                                hbct_pkg::ACT_UNLOCK});
        res_slot  = cur_slot_r;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        // read one slot a cycle, write back the previous one
        rd_en       = 1'b1;
        rd_addr     = cnt_r;
        wr_en       = wb_v_r;
        wr_addr     = wb_addr_r;
        wr_data     = rd_data_r;
        wr_data.valid = rd_data_r.valid && rd_data_r.lock;
        wb_addr_nxt = cnt_r;
        wb_v_nxt    = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_SWEND;
        end
      end
      ST_SWEND: begin
        wr_en         = 1'b1;
        wr_addr       = wb_addr_r;
        wr_data       = rd_data_r;
        wr_data.valid = rd_data_r.valid && rd_data_r.lock;
        wb_v_nxt      = 1'b0;
        res_load      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wb_addr_r <= wb_addr_nxt;
    if (pop) begin
      cur_r      <= q_cmd;
      cur_slot_r <= q_slot;
    end
    if (res_load) begin
      out_hit_r  <= res_hit;
      out_slot_r <= res_slot;
    end
  end

  // tag memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/hashed_block_cache_tag_table.sv
// top level of the hashed block cache tag table
// Direct-mapped tag table for a disk block cache. Request beats enter on the
// in_ stream (action, disk id, sector); every request gives one result beat
// on the out_ stream (hit flag, slot index for the data memory).
// The front hashes the block address in a five-stage pipeline (at most one
// multiplier per stage) and feeds a short queue; the back owns the tag memory.
// Fetch, unlock, store and invalidate read the slot in the back, then write it
// back on the single memory port pair; unknown actions are answered at once;
// invalidate all walks every slot. The back takes a new request only when
// it is done with the last one. After reset the back clears valid and lock
// of every slot, with in_tready low. When the receiver stalls, the result
// register holds, the back stops taking requests, the queue fills and then
// in_tready drops.
module hashed_block_cache_tag_table #(
  parameter int SLOTS       = hbct_pkg::SLOTS_DEF,
  parameter int BLOCK_BITS  = hbct_pkg::BLOCK_BITS_DEF,
  parameter int QUEUE_DEPTH = hbct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fields from bit 0: action[2:0], disk_id[18:3], sector[50:19], zero pad
  input  logic [hbct_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fields from bit 0: hit[0], slot[10:1], zero pad
  output logic [hbct_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int SW = $clog2(SLOTS);
  localparam int QW = $bits(hbct_pkg::cmd_t) + SW;

  logic           clear_busy;
  logic           q_full, q_empty, push, pop;
  hbct_pkg::cmd_t push_cmd, q_cmd;
  logic [SW-1:0]  push_slot, q_slot;
  logic [QW-1:0]  q_in, q_out;

  assign q_in            = {push_slot, push_cmd};
  assign {q_slot, q_cmd} = q_out;

  // hashing front end
  hbct_front #(
    .SLOTS      (SLOTS),
    .BLOCK_BITS (BLOCK_BITS),
    .SW         (SW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_slot  (push_slot)
  );

  // request queue
  hbct_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // tag memory back end
  hbct_back #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_cmd),
    .q_slot     (q_slot),
    .pop        (pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
